@@ sv/mfmc_pkg.sv @@
`timescale 1ns / 1ps
package mfmc_pkg;
    localparam int MaxVertices  = 16;
    localparam int MaxEdges     = 32;
    localparam int CapacityBits = 16;
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    typedef struct packed {
        logic clr_all;
        logic k_init;
        logic bfs_init;
        logic scan_step;
        logic pop;
        logic aug_step;
        logic k_dec;
        logic cut_step;
        logic cut_init;
        logic emit_init;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic q_empty;
        logic at_sink;
        logic aug_done;
        logic k_zero;
        logic no_cap;
        logic cut_done;
        logic cut_hit;
    } t_sts;
endpackage

@@ sv/mfmc_if.sv @@
`timescale 1ns / 1ps
interface mfmc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  from_vertex;
    logic [4:0]  to_vertex;
    logic [15:0] edge_capacity;
    modport source (output valid, command, from_vertex, to_vertex, edge_capacity,
                    input ready);
    modport sink   (input valid, command, from_vertex, to_vertex, edge_capacity,
                    output ready);
endinterface

interface mfmc_out_if;
    logic        valid;
    logic        ready;
    logic        is_header;
    logic [5:0]  cut_count;
    logic [20:0] cut_capacity;
    logic [5:0]  edge_number;
    logic        last;
    modport source (output valid, is_header, cut_count, cut_capacity, edge_number, last,
                    input ready);
    modport sink   (input valid, is_header, cut_count, cut_capacity, edge_number, last,
                    output ready);
endinterface

@@ sv/mfmc_datapath.sv @@
`timescale 1ns / 1ps
module mfmc_datapath import mfmc_pkg::*; #(
    parameter int MAX_VERTICES  = MaxVertices,
    parameter int MAX_EDGES     = MaxEdges,
    parameter int CAPACITY_BITS = CapacityBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [4:0]  i_from,
    input  logic [4:0]  i_to,
    input  logic [15:0] i_cap,
    input  logic [4:0]  i_vcount,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [5:0]  o_cut_count,
    output logic [20:0] o_cut_total,
    output logic [5:0]  o_cut_edge
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = EW + 1;
    localparam int KW = $clog2(CAPACITY_BITS + 1);
    localparam int FW = CAPACITY_BITS + 2;

    logic [VW-1:0]            r_tail [MAX_EDGES];
    logic [VW-1:0]            r_head [MAX_EDGES];
    logic [CAPACITY_BITS-1:0] r_ecap [MAX_EDGES];
    logic signed [FW-1:0]     r_flow [MAX_EDGES];
    logic [MAX_VERTICES-1:0]  r_vis;
    logic [EW:0]              r_parc [MAX_VERTICES];
    logic [VW-1:0]            r_queue [MAX_VERTICES];
    logic [CW-1:0]            r_nedge;
    logic [CAPACITY_BITS-1:0] r_lcap;
    logic [KW-1:0]            r_k;
    logic [VW:0]              r_qh, r_qt;
    logic [VW-1:0]            r_v;
    logic [CW-1:0]            r_e;
    logic [5:0]               r_cnt;
    logic [20:0]              r_tot;

    logic [VW:0] nv;
    logic [VW-1:0] sink;
    logic [VW-1:0] et, eh;
    logic eact;
    logic signed [FW:0] res0, res1, delta;
    logic [EW-1:0] e_idx, a_e;
    logic [EW:0] arc;

    always_comb begin
        if (i_vcount < 5'd2) begin
            nv = (VW+1)'(2);
        end else if (32'(i_vcount) > MAX_VERTICES) begin
            nv = (VW+1)'(MAX_VERTICES);
        end else begin
            nv = (VW+1)'(i_vcount);
        end
        sink  = VW'(nv - 1'b1);
        e_idx = r_e[EW-1:0];
        et    = r_tail[e_idx];
        eh    = r_head[e_idx];
        eact  = ((VW+1)'(et) < nv) && ((VW+1)'(eh) < nv) && (et != eh);
        res0  = (FW+1)'(r_ecap[e_idx]) - (FW+1)'(r_flow[e_idx]);
        res1  = (FW+1)'(r_ecap[e_idx]) + (FW+1)'(r_flow[e_idx]);
        delta = (FW+1)'(1) << r_k;
        arc   = r_parc[r_v];
        a_e   = arc[EW:1];
    end

    logic lk_zero;
    logic [KW-1:0] k_top;
    always_comb begin
        k_top = '0;
        for (int i = 0; i < CAPACITY_BITS; i++) begin
            if (r_lcap[i]) k_top = KW'(i);
        end
        lk_zero = (r_k == '0);
        o_sts.scan_done = (r_e >= r_nedge);
        o_sts.q_empty   = (r_qh >= r_qt);
        o_sts.at_sink   = (r_v == sink);
        o_sts.aug_done  = (r_v == '0);
        o_sts.k_zero    = lk_zero;
        o_sts.no_cap    = (r_lcap == '0);
        o_sts.cut_done  = (r_e >= r_nedge);
        o_sts.cut_hit   = eact && (r_vis[et] != r_vis[eh]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nedge <= '0;
            r_lcap  <= '0;
            r_vis   <= '0;
            for (int i = 0; i < MAX_EDGES; i++) r_flow[i] <= '0;
        end else begin
            if (i_load && i_from >= 5'd1 && 32'(i_from) <= MAX_VERTICES && i_to >= 5'd1 &&
                32'(i_to) <= MAX_VERTICES && 32'(r_nedge) < MAX_EDGES) begin
                r_tail[r_nedge[EW-1:0]] <= VW'(i_from - 5'd1);
                r_head[r_nedge[EW-1:0]] <= VW'(i_to - 5'd1);
                r_ecap[r_nedge[EW-1:0]] <= i_cap[CAPACITY_BITS-1:0];
                r_flow[r_nedge[EW-1:0]] <= '0;
                r_nedge <= r_nedge + 1'b1;
                if (i_cap[CAPACITY_BITS-1:0] > r_lcap) r_lcap <= i_cap[CAPACITY_BITS-1:0];
            end
            if (i_cmd.clr_all) begin
                r_nedge <= '0;
                r_lcap  <= '0;
                for (int i = 0; i < MAX_EDGES; i++) r_flow[i] <= '0;
            end
            if (i_cmd.k_init) r_k <= k_top;
            if (i_cmd.k_dec) r_k <= r_k - 1'b1;
            if (i_cmd.bfs_init) begin
                r_vis      <= MAX_VERTICES'(1);
                r_queue[0] <= '0;
                r_qh       <= '0;
                r_qt       <= (VW+1)'(1);
            end
            if (i_cmd.pop) begin
                r_v  <= r_queue[r_qh[VW-1:0]];
                r_qh <= r_qh + 1'b1;
                r_e  <= '0;
            end
            if (i_cmd.scan_step) begin
                if (eact) begin
                    if (et == r_v && eh != et && !r_vis[eh] && res0 >= delta) begin
                        r_vis[eh]  <= 1'b1;
                        r_parc[eh] <= {e_idx, 1'b0};
                        if (32'(r_qt) < MAX_VERTICES) begin
                            r_queue[r_qt[VW-1:0]] <= eh;
                            r_qt <= r_qt + 1'b1;
                        end
                    end else if (eh == r_v && !r_vis[et] && res1 >= delta) begin
                        r_vis[et]  <= 1'b1;
                        r_parc[et] <= {e_idx, 1'b1};
                        if (32'(r_qt) < MAX_VERTICES) begin
                            r_queue[r_qt[VW-1:0]] <= et;
                            r_qt <= r_qt + 1'b1;
                        end
                    end
                end
                r_e <= r_e + 1'b1;
            end
            if (i_cmd.aug_step) begin
                if (arc[0]) begin
                    r_flow[a_e] <= FW'((FW+1)'(r_flow[a_e]) - delta);
                    r_v <= r_head[a_e];
                end else begin
                    r_flow[a_e] <= FW'((FW+1)'(r_flow[a_e]) + delta);
                    r_v <= r_tail[a_e];
                end
            end
            if (i_cmd.cut_init) begin
                r_e <= '0;
                r_cnt <= '0;
                r_tot <= '0;
            end
            if (i_cmd.cut_step) begin
                if (o_sts.cut_hit) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_tot <= r_tot + 21'(r_ecap[e_idx]);
                end
                r_e <= r_e + 1'b1;
            end
            if (i_cmd.emit_init) r_e <= '0;
            if (i_cmd.emit_step) r_e <= r_e + 1'b1;
        end
    end

    assign o_cut_count = r_cnt;
    assign o_cut_total = r_tot;
    assign o_cut_edge  = 6'(r_e) + 6'd1;
endmodule

@@ sv/mfmc_ctrl.sv @@
`timescale 1ns / 1ps
module mfmc_ctrl import mfmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_solve,
    input  t_sts        i_sts,
    input  logic        i_out_ready,
    output t_cmd        o_cmd,
    output logic        o_busy,
    output logic        o_hdr,
    output logic        o_hit_emit
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_POP, S_SCAN, S_AUG, S_FINAL, S_FPOP, S_FSCAN,
        S_CUT, S_HDR, S_EDGE, S_CLR
    } t_state;
    t_state r_state, n_state;
    logic r_final, n_final;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_final = r_final;
        o_hdr = 1'b0;
        o_hit_emit = 1'b0;
        case (r_state)
            S_IDLE: if (i_solve) begin
                n_final = i_sts.no_cap;
                n_state = i_sts.no_cap ? S_FINAL : S_INIT;
                o_cmd.bfs_init = 1'b1;
                o_cmd.k_init = 1'b1;
            end
            S_INIT: begin
                o_cmd.bfs_init = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    if (r_final || i_sts.k_zero) begin
                        o_cmd.bfs_init = 1'b1;
                        n_state = S_FPOP;
                    end else begin
                        o_cmd.k_dec = 1'b1;
                        o_cmd.bfs_init = 1'b1;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.at_sink) begin
                    n_state = S_AUG;
                end else if (i_sts.scan_done) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_AUG: begin
                if (i_sts.aug_done) begin
                    o_cmd.bfs_init = 1'b1;
                    n_state = S_POP;
                end else begin
                    o_cmd.aug_step = 1'b1;
                end
            end
            S_FINAL: begin
                o_cmd.cut_init = 1'b1;
                n_state = S_HDR;
            end
            S_FPOP: begin
                if (i_sts.q_empty) begin
                    o_cmd.cut_init = 1'b1;
                    n_state = S_CUT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_FSCAN;
                end
            end
            S_FSCAN: begin
                if (i_sts.at_sink || i_sts.scan_done) begin
                    n_state = S_FPOP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_CUT: begin
                if (i_sts.cut_done) begin
                    o_cmd.cut_init = 1'b0;
                    n_state = S_HDR;
                end else begin
                    o_cmd.cut_step = 1'b1;
                end
            end
            S_HDR: begin
                o_hdr = 1'b1;
                if (i_out_ready) begin
                    if (r_final) begin
                        n_state = S_CLR;
                    end else begin
                        o_cmd.emit_init = 1'b1;
                        n_state = S_EDGE;
                    end
                end
            end
            S_EDGE: begin
                if (i_sts.cut_done) begin
                    n_state = S_CLR;
                end else begin
                    o_hit_emit = i_sts.cut_hit;
                    if (!i_sts.cut_hit || i_out_ready) o_cmd.emit_step = 1'b1;
                end
            end
            S_CLR: begin
                o_cmd.clr_all = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

@@ sv/max_flow_min_cut.sv @@
`timescale 1ns / 1ps
// channel  dir  transfer
// s_in     in   command, from_vertex, to_vertex, edge_capacity
// m_out    out  is_header, cut_count, cut_capacity, edge_number, last
// cfg      in   i_cfg_we / i_cfg_data -> vertex_count
// A solve with a nonzero edge capacity runs, per scaling step, BFS passes that
// scan the loaded edges for each dequeued vertex and augment along each path
// found, then a cut scan and an emit scan of one edge a cycle; output stalls
// hold the emit scan. Otherwise only the header is emitted.
// Reset is synchronous active low; input is stalled while a solve runs.
module max_flow_min_cut import mfmc_pkg::*; #(
    parameter int MAX_VERTICES  = MaxVertices,
    parameter int MAX_EDGES     = MaxEdges,
    parameter int CAPACITY_BITS = CapacityBits
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    mfmc_in_if.sink    s_in,
    mfmc_out_if.source m_out
);
    t_cmd cmd;
    t_sts sts;
    logic busy, hdr, hit;
    logic [4:0] r_vcount;
    logic [5:0] cnt, edg;
    logic [20:0] tot;
    logic [5:0] r_emitted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 5'd16;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    assign s_in.ready = !busy;

    mfmc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_solve(s_in.valid && s_in.ready && s_in.command == CMD_SOLVE),
        .i_sts(sts), .i_out_ready(m_out.ready),
        .o_cmd(cmd), .o_busy(busy), .o_hdr(hdr), .o_hit_emit(hit)
    );

    mfmc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
        .CAPACITY_BITS(CAPACITY_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_load(s_in.valid && s_in.ready && s_in.command == CMD_ADD),
        .i_from(s_in.from_vertex), .i_to(s_in.to_vertex), .i_cap(s_in.edge_capacity),
        .i_vcount(r_vcount), .i_cmd(cmd), .o_sts(sts),
        .o_cut_count(cnt), .o_cut_total(tot), .o_cut_edge(edg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted <= '0;
        end else if (hdr && m_out.ready) begin
            r_emitted <= '0;
        end else if (hit && m_out.ready) begin
            r_emitted <= r_emitted + 1'b1;
        end
    end

    assign m_out.valid        = hdr || hit;
    assign m_out.is_header    = hdr;
    assign m_out.cut_count    = hdr ? cnt : 6'd0;
    assign m_out.cut_capacity = hdr ? tot : 21'd0;
    assign m_out.edge_number  = hdr ? 6'd0 : edg;
    assign m_out.last         = hdr ? (cnt == 6'd0) : (r_emitted + 1'b1 == cnt);

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_in.ready) else $error("ready while busy");
    a_hdr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hdr && hit)) else $error("header and edge together");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit && !hdr) |-> (r_emitted < cnt)) else $error("too many cut edges");
endmodule
